// ===== rtl/ppw_pkg.sv =====
// Shared types, constants and helpers for the point projection pipeline.
// No dependencies; every rtl module refers to this package by scoped names.
package ppw_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PW          = 64 - FRAC_BITS;
    localparam int DVW         = 32 + FRAC_BITS;
    localparam int NCOEF       = 32;
    localparam int IDXW        = 5;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 4;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic signed [32:0] ONE_Q     = 33'sh1 << FRAC_BITS;
    localparam logic signed [63:0] SAT_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN64 = -64'sd2147483648;
    localparam logic [31:0]        Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0]        Q_MIN     = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_X      = 4'd0,
        CFG_VIEW_Y      = 4'd1,
        CFG_VIEW_WIDTH  = 4'd2,
        CFG_VIEW_HEIGHT = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic [15:0]        view_width;
        logic [15:0]        view_height;
    } t_vp_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX64) begin
            r = Q_MAX;
        end else if (v < SAT_MIN64) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ppw_xform.sv =====
// Coefficient store and the two matrix transforms, modelview then projection.
// Uses ppw_pkg; four register stages after the input capture stage.
module ppw_xform (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_op,
    input  logic [ppw_pkg::IDXW-1:0]  i_idx,
    input  logic signed [31:0]        i_val,
    input  logic signed [31:0]        i_x,
    input  logic signed [31:0]        i_y,
    input  logic signed [31:0]        i_z,
    output logic                      o_valid,
    output logic [3:0][31:0]          o_clip
);
    localparam int PW   = ppw_pkg::PW;
    localparam int IDXW = ppw_pkg::IDXW;

    logic signed [31:0] r_coef [ppw_pkg::NCOEF];

    logic                r0_valid, r0_op;
    logic [IDXW-1:0]     r0_idx;
    logic signed [31:0]  r0_val;
    logic signed [31:0]  r0_p [3];

    logic                r1_valid, r1_op;
    logic [IDXW-1:0]     r1_idx;
    logic signed [31:0]  r1_val;
    logic signed [PW-1:0] r1_prod [4][3];
    logic signed [31:0]  r1_cst [4];

    logic                r2_valid, r2_op;
    logic [IDXW-1:0]     r2_idx;
    logic signed [31:0]  r2_val;
    logic signed [31:0]  r2_eye [4];

    logic                r3_valid;
    logic signed [PW-1:0] r3_prod [4][4];

    logic                r4_valid;
    logic signed [31:0]  r4_clip [4];

    logic signed [PW-1:0] n1_prod [4][3];
    logic signed [31:0]   n2_eye [4];
    logic signed [PW-1:0] n3_prod [4][4];
    logic signed [31:0]   n4_clip [4];

    always_comb begin
        logic signed [63:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                t = r_coef[IDXW'(c * 4 + r)] * r0_p[c];
                n1_prod[r][c] = t[63:ppw_pkg::FRAC_BITS];
            end
        end
    end

    always_comb begin
        logic signed [63:0] acc;
        acc = '0;
        for (int r = 0; r < 4; r++) begin
            acc = 64'(r1_cst[r]);
            for (int c = 0; c < 3; c++) begin
                acc = acc + 64'(r1_prod[r][c]);
            end
            n2_eye[r] = ppw_pkg::sat32(acc);
        end
    end

    always_comb begin
        logic signed [63:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t = r_coef[IDXW'(16 + c * 4 + r)] * r2_eye[c];
                n3_prod[r][c] = t[63:ppw_pkg::FRAC_BITS];
            end
        end
    end

    always_comb begin
        logic signed [63:0] acc;
        acc = '0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + 64'(r3_prod[r][c]);
            end
            n4_clip[r] = ppw_pkg::sat32(acc);
        end
    end

    // modelview slots load on the accepted beat, projection slots from stage two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppw_pkg::NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_valid && i_op == ppw_pkg::OP_WRITE && !i_idx[IDXW-1]) begin
                r_coef[i_idx] <= i_val;
            end
            if (i_en && r2_valid && r2_op == ppw_pkg::OP_WRITE && r2_idx[IDXW-1]) begin
                r_coef[r2_idx] <= r2_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid && r2_op == ppw_pkg::OP_PROJECT;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_op   <= i_op;
            r0_idx  <= i_idx;
            r0_val  <= i_val;
            r0_p[0] <= i_x;
            r0_p[1] <= i_y;
            r0_p[2] <= i_z;
            r1_op   <= r0_op;
            r1_idx  <= r0_idx;
            r1_val  <= r0_val;
            r2_op   <= r1_op;
            r2_idx  <= r1_idx;
            r2_val  <= r1_val;
            for (int r = 0; r < 4; r++) begin
                r1_cst[r]  <= r_coef[IDXW'(12 + r)];
                r2_eye[r]  <= n2_eye[r];
                r4_clip[r] <= n4_clip[r];
                for (int c = 0; c < 3; c++) begin
                    r1_prod[r][c] <= n1_prod[r][c];
                end
                for (int c = 0; c < 4; c++) begin
                    r3_prod[r][c] <= n3_prod[r][c];
                end
            end
        end
    end

    assign o_valid = r4_valid;
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            o_clip[r] = r4_clip[r];
        end
    end

    a_m_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && i_op == ppw_pkg::OP_WRITE && !i_idx[IDXW-1]
        |=> r_coef[$past(i_idx)] == $past(i_val))
        else $error("modelview coefficient not loaded");

    a_p_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_en && r2_valid && r2_op == ppw_pkg::OP_WRITE && r2_idx[IDXW-1]
        |=> r_coef[$past(r2_idx)] == $past(r2_val))
        else $error("projection coefficient not loaded");

endmodule

// ===== rtl/ppw_div.sv =====
// Pipelined restoring divider for the perspective divide, three lanes by clip w.
// Uses ppw_pkg; one quotient bit per stage, then sign and saturation.
module ppw_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [3:0][31:0] i_clip,
    output logic             o_valid,
    output logic             o_wzero,
    output logic [2:0][31:0] o_ndc
);
    localparam int DVW = ppw_pkg::DVW;

    logic             r_v    [DVW+1];
    logic             r_wz   [DVW+1];
    logic [31:0]      r_d    [DVW+1];
    logic [2:0]       r_neg  [DVW+1];
    logic [31:0]      r_rem  [DVW+1][3];
    logic [DVW-1:0]   r_dq   [DVW+1][3];

    logic             r_ov, r_owz;
    logic [31:0]      r_ndc [3];

    logic [31:0]      w_absw;
    logic [31:0]      w_absc [3];
    logic [32:0]      w_t    [DVW+1][3];
    logic [32:0]      w_diff [DVW+1][3];
    logic [31:0]      n_ndc  [3];

    always_comb begin
        w_absw = i_clip[3][31] ? 32'(-i_clip[3]) : i_clip[3];
        for (int l = 0; l < 3; l++) begin
            w_absc[l] = i_clip[l][31] ? 32'(-i_clip[l]) : i_clip[l];
        end
    end

    always_comb begin
        for (int s = 0; s <= DVW; s++) begin
            for (int l = 0; l < 3; l++) begin
                w_t[s][l]    = {r_rem[s][l], r_dq[s][l][DVW-1]};
                w_diff[s][l] = w_t[s][l] - {1'b0, r_d[s]};
            end
        end
    end

    always_comb begin
        logic [DVW-1:0] q;
        logic           over;
        q    = '0;
        over = 1'b0;
        for (int l = 0; l < 3; l++) begin
            q    = r_dq[DVW][l];
            over = |q[DVW-1:32];
            if (r_neg[DVW][l]) begin
                n_ndc[l] = (over || (q[31] && |q[30:0])) ? ppw_pkg::Q_MIN : 32'(-q[31:0]);
            end else begin
                n_ndc[l] = (over || q[31]) ? ppw_pkg::Q_MAX : q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DVW; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= DVW; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[DVW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wz[0] <= i_clip[3] == '0;
            r_d[0]  <= w_absw;
            for (int l = 0; l < 3; l++) begin
                r_neg[0][l] <= i_clip[l][31] ^ i_clip[3][31];
                r_rem[0][l] <= '0;
                r_dq[0][l]  <= {w_absc[l], {ppw_pkg::FRAC_BITS{1'b0}}};
            end
            for (int s = 1; s <= DVW; s++) begin
                r_wz[s]  <= r_wz[s-1];
                r_d[s]   <= r_d[s-1];
                r_neg[s] <= r_neg[s-1];
                for (int l = 0; l < 3; l++) begin
                    if (!w_diff[s-1][l][32]) begin
                        r_rem[s][l] <= w_diff[s-1][l][31:0];
                        r_dq[s][l]  <= {r_dq[s-1][l][DVW-2:0], 1'b1};
                    end else begin
                        r_rem[s][l] <= w_t[s-1][l][31:0];
                        r_dq[s][l]  <= {r_dq[s-1][l][DVW-2:0], 1'b0};
                    end
                end
            end
            r_owz <= r_wz[DVW];
            for (int l = 0; l < 3; l++) begin
                r_ndc[l] <= n_ndc[l];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_wzero = r_owz;
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_ndc[l] = r_ndc[l];
        end
    end

endmodule

// ===== rtl/ppw_vp.sv =====
// Viewport and depth mapping of the normalised coordinates, plus output register.
// Uses ppw_pkg for the config struct, constants and saturation.
module ppw_vp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_wzero,
    input  logic [2:0][31:0]  i_ndc,
    input  ppw_pkg::t_vp_cfg  i_cfg,
    output logic              o_valid,
    output logic [2:0][31:0]  o_win,
    output logic              o_ok
);
    localparam int F = ppw_pkg::FRAC_BITS;

    logic               r1_valid, r1_wz;
    logic signed [49:0] r1_mx, r1_my;
    logic signed [32:0] r1_z;

    logic               r2_valid, r2_ok;
    logic [31:0]        r2_win [3];

    logic signed [32:0] w_nx, w_ny, w_nz;
    logic signed [63:0] w_sx, w_sy;

    assign w_nx = 33'($signed(i_ndc[0]));
    assign w_ny = 33'($signed(i_ndc[1]));
    assign w_nz = 33'($signed(i_ndc[2]));

    assign w_sx = 64'(r1_mx >>> 1) + (64'(i_cfg.view_x) <<< F);
    assign w_sy = 64'(r1_my >>> 1) + (64'(i_cfg.view_y) <<< F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_wz <= i_wzero;
            r1_mx <= (w_nx + ppw_pkg::ONE_Q) * $signed({1'b0, i_cfg.view_width});
            r1_my <= (ppw_pkg::ONE_Q - w_ny) * $signed({1'b0, i_cfg.view_height});
            r1_z  <= w_nz + ppw_pkg::ONE_Q;
            r2_ok <= !r1_wz;
            if (r1_wz) begin
                r2_win[0] <= '0;
                r2_win[1] <= '0;
                r2_win[2] <= '0;
            end else begin
                r2_win[0] <= ppw_pkg::sat32(w_sx);
                r2_win[1] <= ppw_pkg::sat32(w_sy);
                r2_win[2] <= ppw_pkg::sat32(64'(r1_z >>> 1));
            end
        end
    end

    assign o_valid = r2_valid;
    assign o_ok    = r2_ok;
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_win[l] = r2_win[l];
        end
    end

endmodule

// ===== rtl/point_projection_to_window.sv =====
// Point projection to window coordinates: one beat accepted per cycle.
// An accepted project beat passes capture and the two matrix transforms,
// then the 48 stage divider and finally the viewport to its result beat.
// Throughput is one beat per cycle; a stalled output halts every stage together.
// Synchronous active-low reset clears the coefficients and loads viewport 0,0,640,480.
module point_projection_to_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // coef_index[4:0], coef_value[36:5], obj_x[68:37], obj_y[100:69], obj_z[132:101]
    input  logic [ppw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // win_x[31:0], win_y[63:32], win_z[95:64]
    output logic [ppw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // ok[0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);
    ppw_pkg::t_vp_cfg r_cfg;

    logic             w_en, w_in_beat;
    logic             w_x_valid, w_d_valid, w_d_wz, w_ok;
    logic [3:0][31:0] w_clip;
    logic [2:0][31:0] w_ndc, w_win;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_in_beat     = s_axis_tvalid && w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_x      <= '0;
            r_cfg.view_y      <= '0;
            r_cfg.view_width  <= 16'd640;
            r_cfg.view_height <= 16'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppw_pkg::CFG_VIEW_X:      r_cfg.view_x      <= i_cfg_data;
                ppw_pkg::CFG_VIEW_Y:      r_cfg.view_y      <= i_cfg_data;
                ppw_pkg::CFG_VIEW_WIDTH:  r_cfg.view_width  <= i_cfg_data;
                ppw_pkg::CFG_VIEW_HEIGHT: r_cfg.view_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppw_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_beat),
        .i_op    (s_axis_tuser[0]),
        .i_idx   (s_axis_tdata[4:0]),
        .i_val   (s_axis_tdata[36:5]),
        .i_x     (s_axis_tdata[68:37]),
        .i_y     (s_axis_tdata[100:69]),
        .i_z     (s_axis_tdata[132:101]),
        .o_valid (w_x_valid),
        .o_clip  (w_clip)
    );

    ppw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_x_valid),
        .i_clip  (w_clip),
        .o_valid (w_d_valid),
        .o_wzero (w_d_wz),
        .o_ndc   (w_ndc)
    );

    ppw_vp u_vp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_wzero (w_d_wz),
        .i_ndc   (w_ndc),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .o_win   (w_win),
        .o_ok    (w_ok)
    );

    assign m_axis_tdata    = {w_win[2], w_win[1], w_win[0]};
    assign m_axis_tuser[0] = w_ok;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("failed projection beat carries nonzero coordinates");

endmodule
